// ----- rtl/tpsd_pkg.sv -----
// Shared types and constants for the TGA pixel stream decoder.
// No dependencies; used by every module of the block.
`default_nettype none
package tpsd_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_TOTAL = 2'd2;

  typedef enum logic [1:0] {
    FMT16,
    FMT24,
    FMT32
  } fmt_t;

  // One assembled pixel on its way from the front to the back.
  typedef struct packed {
    logic [23:0] held;
    logic [7:0]  last;
    fmt_t        fmt;
    logic [7:0]  count;
    logic        done;
  } pix_t;

endpackage
`default_nettype wire

// ----- rtl/tpsd_front.sv -----
// Front of the decoder: takes bytes, parses packet heads, assembles pixels,
// clips runs against the pixel total. Holds the configuration registers. Uses tpsd_pkg.
`default_nettype none
module tpsd_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             image_start,
  input  wire logic                             cfg_wen,
  input  wire logic [tpsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tpsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             full,
  output logic                                  push,
  output tpsd_pkg::pix_t                        push_data
);

  logic [2:0]  pixel_bytes;
  logic        rle_mode;
  logic [31:0] pixel_total;

  logic        expect_head;
  logic [1:0]  byte_index;
  logic [23:0] held;
  logic        run_is_repeat;
  logic [6:0]  raw_left;
  logic [7:0]  run_length;
  logic [31:0] pixels_done;
  logic [31:0] remain;
  logic        finished;

  logic        expect_head_e, expect_head_next;
  logic [1:0]  byte_index_e, byte_index_next;
  logic [23:0] held_e, held_next;
  logic        run_is_repeat_e, run_is_repeat_next;
  logic [6:0]  raw_left_e, raw_left_next;
  logic [7:0]  run_length_e, run_length_next;
  logic [31:0] pixels_done_e, pixels_done_next;
  logic [31:0] remain_e, remain_next;
  logic        finished_e, finished_next;

  logic [2:0]     nbytes;
  tpsd_pkg::fmt_t fmt;
  logic [7:0]     count;
  logic [7:0]     clipped;
  logic           emit;
  logic           accept;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign push     = accept && emit;

  always_comb begin
    case (pixel_bytes)
      3'd2: begin
        nbytes = 3'd2;
        fmt    = tpsd_pkg::FMT16;
      end
      3'd3: begin
        nbytes = 3'd3;
        fmt    = tpsd_pkg::FMT24;
      end
      default: begin
        nbytes = 3'd4;
        fmt    = tpsd_pkg::FMT32;
      end
    endcase
  end

  // Restart clears the decoding state ahead of the byte that carries it.
  always_comb begin
    expect_head_e   = image_start | expect_head;
    byte_index_e    = image_start ? 2'd0 : byte_index;
    held_e          = image_start ? 24'd0 : held;
    run_is_repeat_e = image_start ? 1'b0 : run_is_repeat;
    raw_left_e      = image_start ? 7'd0 : raw_left;
    run_length_e    = image_start ? 8'd0 : run_length;
    pixels_done_e   = image_start ? 32'd0 : pixels_done;
    remain_e        = image_start ? pixel_total : remain;
    finished_e      = image_start ? (pixel_total == 32'd0) : finished;
  end

  always_comb begin
    expect_head_next   = expect_head_e;
    byte_index_next    = byte_index_e;
    held_next          = held_e;
    run_is_repeat_next = run_is_repeat_e;
    raw_left_next      = raw_left_e;
    run_length_next    = run_length_e;
    pixels_done_next   = pixels_done_e;
    remain_next        = remain_e;
    finished_next      = finished_e;
    emit               = 1'b0;
    count              = 8'd1;
    clipped            = 8'd1;
    if (!finished_e) begin
      if (rle_mode && expect_head_e) begin
        run_is_repeat_next = data_byte[7];
        if (data_byte[7]) begin
          run_length_next = {1'b0, data_byte[6:0]} + 8'd1;
          raw_left_next   = 7'd0;
        end else begin
          raw_left_next = data_byte[6:0];
        end
        expect_head_next = 1'b0;
        byte_index_next  = 2'd0;
      end else if (({1'b0, byte_index_e} + 3'd1) < nbytes) begin
        case (byte_index_e)
          2'd0:    held_next[7:0]   = data_byte;
          2'd1:    held_next[15:8]  = data_byte;
          2'd2:    held_next[23:16] = data_byte;
          default: held_next        = held_e;
        endcase
        byte_index_next = byte_index_e + 2'd1;
      end else begin
        byte_index_next = 2'd0;
        emit            = 1'b1;
        if (rle_mode) begin
          if (run_is_repeat_e) begin
            count            = run_length_e;
            expect_head_next = 1'b1;
          end else if (raw_left_e == 7'd0) begin
            expect_head_next = 1'b1;
          end else begin
            raw_left_next = raw_left_e - 7'd1;
          end
        end
        // Clip to what is left of the image.
        if (remain_e[31:8] == 24'd0 && count > remain_e[7:0]) begin
          clipped = remain_e[7:0];
        end else begin
          clipped = count;
        end
        pixels_done_next = pixels_done_e + {24'd0, clipped};
        remain_next      = remain_e - {24'd0, clipped};
        finished_next    = (remain_e == {24'd0, clipped});
      end
    end
  end

  always_comb begin
    push_data.held  = held_e;
    push_data.last  = data_byte;
    push_data.fmt   = fmt;
    push_data.count = clipped;
    push_data.done  = finished_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bytes   <= 3'd3;
      rle_mode      <= 1'b0;
      pixel_total   <= 32'd1;
      expect_head   <= 1'b1;
      byte_index    <= 2'd0;
      held          <= 24'd0;
      run_is_repeat <= 1'b0;
      raw_left      <= 7'd0;
      run_length    <= 8'd0;
      pixels_done   <= 32'd0;
      remain        <= 32'd1;
      finished      <= 1'b0;
    end else begin
      if (accept) begin
        expect_head   <= expect_head_next;
        byte_index    <= byte_index_next;
        held          <= held_next;
        run_is_repeat <= run_is_repeat_next;
        raw_left      <= raw_left_next;
        run_length    <= run_length_next;
        pixels_done   <= pixels_done_next;
        remain        <= remain_next;
        finished      <= finished_next;
      end
      if (cfg_wen) begin
        case (cfg_index)
          tpsd_pkg::REG_PIXEL_BYTES: pixel_bytes <= cfg_data[2:0];
          tpsd_pkg::REG_RLE_MODE:    rle_mode    <= cfg_data[0];
          tpsd_pkg::REG_PIXEL_TOTAL: begin
            // Keep the remaining count and end flag in step with the new total.
            pixel_total <= cfg_data;
            remain      <= cfg_data - pixels_done;
            finished    <= (pixels_done >= cfg_data);
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tpsd_queue.sv -----
// Two-entry queue of assembled pixels between front and back.
// Uses tpsd_pkg for the entry type.
`default_nettype none
module tpsd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tpsd_pkg::pix_t push_data,
  input  wire logic           pop,
  output tpsd_pkg::pix_t      pop_data,
  output logic                full,
  output logic                empty
);

  tpsd_pkg::pix_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tpsd_back.sv -----
// Back of the decoder: widens the assembled pixel to RGBA and holds it in the
// output register until taken. Uses tpsd_pkg.
`default_nettype none
module tpsd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           empty,
  input  wire tpsd_pkg::pix_t pop_data,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic [7:0]          alpha,
  output logic [7:0]          repeat_res,
  output logic                image_done
);

  logic [7:0] r_fmt, g_fmt, b_fmt, a_fmt;
  logic [7:0] b0;

  assign b0  = pop_data.held[7:0];
  assign pop = !empty && (!out_valid || out_ready);

  always_comb begin
    case (pop_data.fmt)
      tpsd_pkg::FMT16: begin
        r_fmt = {pop_data.last[6:2], 3'b000};
        g_fmt = {pop_data.last[1:0], b0[7:5], 3'b000};
        b_fmt = {b0[4:0], 3'b000};
        a_fmt = {pop_data.last[7], 7'd0};
      end
      tpsd_pkg::FMT24: begin
        r_fmt = pop_data.last;
        g_fmt = pop_data.held[15:8];
        b_fmt = b0;
        a_fmt = 8'hff;
      end
      default: begin
        r_fmt = pop_data.held[23:16];
        g_fmt = pop_data.held[15:8];
        b_fmt = b0;
        a_fmt = pop_data.last;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      red        <= r_fmt;
      green      <= g_fmt;
      blue       <= b_fmt;
      alpha      <= a_fmt;
      repeat_res <= pop_data.count;
      image_done <= pop_data.done;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tga_pixel_stream_decoder.sv -----
// TGA pixel stream decoder, top level: front, two-entry queue, back.
// Throughput: one byte per clock while the queue is not full; header and partial-pixel
// bytes give no result. Each result goes from the byte that completes its pixel into the
// queue, then into the output register.
// Reset: synchronous rst restores register defaults and clears decoding state
// and the queue; no clearing pass. Depends on tpsd_pkg, tpsd_front, tpsd_queue, tpsd_back.
`default_nettype none
module tga_pixel_stream_decoder (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             image_start,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [7:0]                            red,
  output logic [7:0]                            green,
  output logic [7:0]                            blue,
  output logic [7:0]                            alpha,
  output logic [7:0]                            repeat_res,
  output logic                                  image_done,
  input  wire logic                             cfg_wen,
  input  wire logic [tpsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tpsd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  tpsd_pkg::pix_t push_data;
  tpsd_pkg::pix_t pop_data;

  tpsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .image_start (image_start),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .full        (full),
    .push        (push),
    .push_data   (push_data)
  );

  tpsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  tpsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .repeat_res (repeat_res),
    .image_done (image_done)
  );

endmodule
`default_nettype wire

// ----- test/tga_pixel_decode_checker.sv -----
`timescale 1ns / 1ps
// Checker for the TGA pixel stream decoder: follows register writes and byte beats,
// predicts each decoded pixel and compares it against the result port. Uses tpsd_pkg.
module tga_pixel_decode_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [7:0]                      data_byte,
  input  logic                            image_start,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  input  logic [7:0]                      alpha,
  input  logic [7:0]                      repeat_res,
  input  logic                            image_done,
  input  logic                            cfg_wen,
  input  logic [tpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpsd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              pending
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] count;
    logic       done;
  } pixel_out_t;

  pixel_out_t pixels_due[$];
  int         fail_cnt = 0;

  // register copies
  logic [2:0]  bpp_reg;
  logic        rle_reg;
  logic [31:0] total_reg;

  // decoding state
  logic        want_head;
  logic [1:0]  byte_pos;
  logic [23:0] held;
  logic        run_rep;
  logic [6:0]  raw_left;
  logic [7:0]  run_len;
  logic [31:0] pix_count;

  function automatic void clear_decode();
    want_head = 1'b1;
    byte_pos  = '0;
    held      = '0;
    run_rep   = 1'b0;
    raw_left  = '0;
    run_len   = '0;
    pix_count = '0;
  endfunction

  // Returns 1 when the byte completes a pixel that goes out.
  function automatic bit decode_byte(input logic [7:0] b, input logic restart,
                                     output pixel_out_t px);
    tpsd_pkg::fmt_t fmt;
    int unsigned    last_pos;
    logic [31:0]    cnt;
    logic [31:0]    left;
    px = '0;
    if (restart) clear_decode();
    if (pix_count >= total_reg) return 1'b0;
    if (rle_reg && want_head) begin
      run_rep = b[7];
      if (b[7]) begin
        run_len  = {1'b0, b[6:0]} + 8'd1;
        raw_left = '0;
      end else begin
        raw_left = b[6:0];
      end
      want_head = 1'b0;
      byte_pos  = '0;
      return 1'b0;
    end
    case (bpp_reg)
      3'd2: fmt = tpsd_pkg::FMT16;
      3'd3: fmt = tpsd_pkg::FMT24;
      default: fmt = tpsd_pkg::FMT32;
    endcase
    last_pos = (fmt == tpsd_pkg::FMT16) ? 1 : (fmt == tpsd_pkg::FMT24) ? 2 : 3;
    if (byte_pos < last_pos) begin
      held[8*byte_pos +: 8] = b;
      byte_pos = byte_pos + 2'd1;
      return 1'b0;
    end
    byte_pos = '0;
    case (fmt)
      tpsd_pkg::FMT16: begin
        px.red   = {b[6:2], 3'b000};
        px.green = {b[1:0], held[7:5], 3'b000};
        px.blue  = {held[4:0], 3'b000};
        px.alpha = {b[7], 7'b0};
      end
      tpsd_pkg::FMT24: begin
        px.red   = b;
        px.green = held[15:8];
        px.blue  = held[7:0];
        px.alpha = 8'hff;
      end
      default: begin
        px.red   = held[23:16];
        px.green = held[15:8];
        px.blue  = held[7:0];
        px.alpha = b;
      end
    endcase
    cnt = 32'd1;
    if (rle_reg) begin
      if (run_rep) begin
        cnt = {24'b0, run_len};
        want_head = 1'b1;
      end else if (raw_left == 0) begin
        want_head = 1'b1;
      end else begin
        raw_left = raw_left - 7'd1;
      end
    end
    // clip to what is left of the image
    left = total_reg - pix_count;
    if (cnt > left) cnt = left;
    pix_count = pix_count + cnt;
    px.count = cnt[7:0];
    px.done  = (pix_count >= total_reg);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    pixel_out_t px;
    pixel_out_t got;
    if (rst) begin
      bpp_reg   = 3'd3;
      rle_reg   = 1'b0;
      total_reg = 32'd1;
      clear_decode();
      pixels_due.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          tpsd_pkg::REG_PIXEL_BYTES: bpp_reg   = cfg_data[2:0];
          tpsd_pkg::REG_RLE_MODE:    rle_reg   = cfg_data[0];
          tpsd_pkg::REG_PIXEL_TOTAL: total_reg = cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (decode_byte(data_byte, image_start, px)) pixels_due.push_back(px);
      end
      if (out_valid && out_ready) begin
        got = {red, green, blue, alpha, repeat_res, image_done};
        if (pixels_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected pixel: r=%02h g=%02h b=%02h a=%02h n=%0d done=%0b",
                     got.red, got.green, got.blue, got.alpha, got.count, got.done);
        end else begin
          px = pixels_due.pop_front();
          if (got !== px) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: exp %02h %02h %02h %02h n=%0d d=%0b got %02h %02h %02h %02h n=%0d d=%0b",
                       px.red, px.green, px.blue, px.alpha, px.count, px.done,
                       got.red, got.green, got.blue, got.alpha, got.count, got.done);
          end
        end
      end
    end
    errors  <= fail_cnt;
    pending <= pixels_due.size();
  end

endmodule

// ----- test/tb_tga_pixel_stream_decoder.sv -----
`timescale 1ns / 1ps
// Testbench top for the TGA pixel stream decoder: drives byte beats and register writes,
// and gives the verdict. Depends on tpsd_pkg, the block and tga_pixel_decode_checker.
module tb_tga_pixel_stream_decoder;

  localparam int RANDOM_BEATS = 1000;
  localparam int SETTLE       = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;

  logic                            clk         = 1'b0;
  logic                            rst         = 1'b1;
  logic                            in_valid    = 1'b0;
  logic [7:0]                      data_byte   = 8'h00;
  logic                            image_start = 1'b0;
  logic                            out_ready   = 1'b0;
  logic                            cfg_wen     = 1'b0;
  logic [tpsd_pkg::CFG_IDX_W-1:0]  cfg_index   = tpsd_pkg::REG_PIXEL_BYTES;
  logic [tpsd_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
  logic                            in_ready;
  logic                            out_valid;
  logic [7:0]                      red, green, blue, alpha, repeat_res;
  logic                            image_done;
  int                              errors;
  int                              pending;

  int src_idle  = 16;
  int sink_idle = 64;
  int beats_sent = 0;
  int cycles = 0;
  bit hold_req = 1'b0;
  bit fresh_pending = 1'b0;

  tga_pixel_stream_decoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .image_start(image_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .repeat_res(repeat_res), .image_done(image_done),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tga_pixel_decode_checker decode_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .image_start(image_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .repeat_res(repeat_res), .image_done(image_done),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= sink_idle);
      end
    end
  end

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic settle();
    wait_drain();
    repeat (SETTLE) @(posedge clk);
  endtask

  // Hold the beat until accepted, then maybe leave a gap.
  task automatic send_beat(input logic [7:0] d, input logic restart);
    int gap;
    in_valid    <= 1'b1;
    data_byte   <= d;
    image_start <= restart;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else if ($urandom_range(0, 199) == 0) begin
      wait_drain();
    end
  endtask

  task automatic set_config(input logic [2:0] px_bytes, input logic rle,
                            input logic [31:0] total);
    logic [31:0] junk;
    junk = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom;
    cfg_wen   <= 1'b1;
    cfg_index <= tpsd_pkg::REG_PIXEL_BYTES;
    cfg_data  <= {junk[31:3], px_bytes};
    @(posedge clk);
    cfg_index <= tpsd_pkg::REG_RLE_MODE;
    cfg_data  <= {junk[31:1], rle};
    @(posedge clk);
    cfg_index <= tpsd_pkg::REG_PIXEL_TOTAL;
    cfg_data  <= total;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Restart on the first byte of a fresh image, and now and then mid-stream.
  task automatic send_data(input logic [7:0] d);
    logic restart;
    restart = fresh_pending || ($urandom_range(0, 99) < 2);
    fresh_pending = 1'b0;
    send_beat(d, restart);
  endtask

  task automatic send_image(input int nbytes, input logic rle, input logic [31:0] total);
    int          target, made, run, k;
    logic [6:0]  len_field;
    target = (total == 0 || total > 200) ? $urandom_range(3, 30) : total;
    made = 0;
    while (made < target) begin
      if ($urandom_range(0, 99) < 3) break;
      if (!rle) begin
        repeat (nbytes) send_data(rand_byte());
        made++;
      end else if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0: run = 128;
          1: run = $urandom_range(1, 128);
          default: run = $urandom_range(1, 6);
        endcase
        len_field = 7'(run - 1);
        send_data({1'b1, len_field});
        repeat (nbytes) send_data(rand_byte());
        made += run;
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 5);
        len_field = 7'(run - 1);
        send_data({1'b0, len_field});
        for (k = 0; k < run && made < target; k++) begin
          repeat (nbytes) send_data(rand_byte());
          made++;
        end
      end
    end
    // trailing bytes past the end of the image
    repeat ($urandom_range(0, 2)) send_data(rand_byte());
  endtask

  initial begin
    int          rand_start, progress, image_no, nbytes;
    logic [2:0]  px_bytes;
    logic        rle;
    logic [31:0] total;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 24-bit raw pixels: black, white and one more, then a byte past the end
    set_config(3'd3, 1'b0, 32'd3);
    send_beat(8'h00, 1'b1); send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0);
    send_beat(8'hff, 1'b0); send_beat(8'hff, 1'b0); send_beat(8'hff, 1'b0);
    send_beat(8'h12, 1'b0); send_beat(8'h34, 1'b0); send_beat(8'h56, 1'b0);
    send_beat(8'h77, 1'b0);
    settle();

    // 16-bit packets: repeat of 2, raw of 2, repeat of 128 clipped to the total
    set_config(3'd2, 1'b1, 32'd5);
    send_beat(8'h81, 1'b1); send_beat(8'hff, 1'b0); send_beat(8'hff, 1'b0);
    send_beat(8'h01, 1'b0); send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0);
    send_beat(8'he0, 1'b0); send_beat(8'h03, 1'b0);
    send_beat(8'hff, 1'b0); send_beat(8'h1f, 1'b0); send_beat(8'h7c, 1'b0);
    send_beat(8'h55, 1'b0);
    settle();

    // odd byte count acts as 32-bit; restart in the middle of a pixel
    set_config(3'd7, 1'b0, 32'd2);
    send_beat(8'h11, 1'b1); send_beat(8'h22, 1'b0);
    send_beat(8'haa, 1'b1); send_beat(8'hbb, 1'b0); send_beat(8'hcc, 1'b0);
    send_beat(8'hdd, 1'b0);
    settle();

    rand_start = beats_sent;
    image_no = 0;
    while (beats_sent - rand_start < RANDOM_BEATS) begin
      progress = beats_sent - rand_start;
      if (progress < RANDOM_BEATS / 3) begin
        src_idle = 16; sink_idle = 64;
      end else if (progress < 2 * RANDOM_BEATS / 3) begin
        src_idle = 64; sink_idle = 16;
      end else begin
        src_idle = 0; sink_idle = 0;
      end

      px_bytes = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(2, 4));
      rle = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0: total = 32'd0;
        1: total = 32'd1;
        2: total = 32'hffff_ffff;
        3: total = 32'hfffe_0001;
        4, 5: total = $urandom_range(100, 200);
        default: total = $urandom_range(1, 24);
      endcase
      fresh_pending = ($urandom_range(0, 9) != 0);

      // one image with the result side held off long enough to back up the input
      if (image_no == 2) begin
        px_bytes = 3'd2; rle = 1'b0; total = 32'd40; fresh_pending = 1'b1;
      end

      settle();
      set_config(px_bytes, rle, total);
      if (image_no == 2) hold_req = 1'b1;
      nbytes = (px_bytes == 3'd2 || px_bytes == 3'd3) ? int'(px_bytes) : 4;
      send_image(nbytes, rle, total);
      image_no++;
    end

    wait_drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tpsd_pkg.sv
rtl/tpsd_front.sv
rtl/tpsd_queue.sv
rtl/tpsd_back.sv
rtl/tga_pixel_stream_decoder.sv
test/tga_pixel_decode_checker.sv
test/tb_tga_pixel_stream_decoder.sv
